// ----- rtl/core/tdpt_pkg.sv -----
// Shared constants, types and helpers for the trial-division prime tester.
// Used by tdpt_div and trial_division_prime_test; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package tdpt_pkg;

    // Width of the datapath that the test runs on.
    localparam int VALUE_WIDTH = 32;
    // Fixed width of the candidate and echo fields on the stream ports.
    localparam int CAND_WIDTH  = 32;
    // Bits shared between a stream word and the datapath.
    localparam int COMMON_W    = (VALUE_WIDTH < CAND_WIDTH) ? VALUE_WIDTH : CAND_WIDTH;
    // Step counter for the bit-serial divider.
    localparam int CNT_W       = $clog2(VALUE_WIDTH);

    typedef logic [VALUE_WIDTH-1:0] t_value;
    typedef logic [CAND_WIDTH-1:0]  t_cand;

    // Control from the sequencer to the divider.
    typedef struct packed {
        logic   start;
        t_value dividend;
        t_value divisor;
    } t_div_req;

    // Status and result from the divider back to the sequencer.
    typedef struct packed {
        logic   busy;
        logic   done;
        t_value quotient;
        logic   rem_zero;
    } t_div_rsp;

    // Keep the low bits of a stream word that fit the datapath.
    function automatic t_value to_value(input t_cand c);
        t_value v;
        v = '0;
        for (int i = 0; i < COMMON_W; i++) begin
            v[i] = c[i];
        end
        return v;
    endfunction

    // Zero-extend or truncate a datapath value back to the stream width.
    function automatic t_cand to_cand(input t_value v);
        t_cand c;
        c = '0;
        for (int i = 0; i < COMMON_W; i++) begin
            c[i] = v[i];
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tdpt_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on tdpt_pkg for widths and the request/response structs.
`timescale 1ns / 1ps
`default_nettype none

module tdpt_div
    import tdpt_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    t_value           r_quo;
    t_value           r_rem;
    t_value           r_dsr;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [VALUE_WIDTH:0] w_shift;
    logic [VALUE_WIDTH:0] w_diff;
    logic                 w_fit;

    // Shift the next dividend bit into the partial remainder and trial-subtract.
    assign w_shift = {r_rem, r_quo[VALUE_WIDTH-1]};
    assign w_diff  = w_shift - {1'b0, r_dsr};
    assign w_fit   = ~w_diff[VALUE_WIDTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(VALUE_WIDTH - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dsr <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[VALUE_WIDTH-2:0], w_fit};
            r_rem <= w_fit ? w_diff[VALUE_WIDTH-1:0] : w_shift[VALUE_WIDTH-1:0];
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
    assign o_rsp.rem_zero = (r_rem == '0);

    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> r_busy)
        else $error("divider did not start");
    a_last_step_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_req.start && r_cnt == '0) |=> (r_done && !r_busy))
        else $error("divider missed its last step");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still busy");

endmodule

`default_nettype wire

// ----- rtl/core/trial_division_prime_test.sv -----
// Trial-division prime tester: top level with the trial sequencer and stream ports.
// Depends on tdpt_pkg and tdpt_div.
//
// Usage:
//   Input stream (i_s_*): one word per candidate, tdata = candidate[31:0].
//   Output stream (o_m_*): one word per candidate, tdata = tested_value[31:0],
//   tuser = prime_flag (1 when the candidate is prime).
//   Results leave in the order the candidates arrived, one per candidate.
// Test flow:
//   Values below 3 and even values are settled at acceptance, with no division:
//   the sequencer goes to its done state, which loads the output register. An
//   odd value runs one trial per odd divisor 3, 5, 7 and so on, each trial a full
//   bit-serial division in the shared divider; the division gives both the
//   quotient for the bound test (divisor > quotient ends the search as prime)
//   and the remainder. A 32-bit prime near 2^32 takes about 32767 trials.
// Throughput:
//   One candidate at a time. The next candidate is accepted as soon as the
//   sequencer is idle, even while the previous result still sits in the
//   output register.
// Reset:
//   i_rst_n is synchronous, active low; it drops any test in flight and any
//   pending result.
// Stall:
//   If the receiver holds i_m_tready low, the output word holds, and a
//   finished test waits in its done state until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module trial_division_prime_test
    import tdpt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [CAND_WIDTH-1:0] i_s_tdata,   // [31:0] candidate
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [CAND_WIDTH-1:0]      o_m_tdata,   // [31:0] tested_value
    output logic                       o_m_tuser    // [0] prime_flag
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state   r_state, n_state;
    t_value   r_n;        // candidate under test, masked to the datapath width
    t_value   r_d, n_d;   // current odd trial divisor
    logic     r_prime, n_prime;
    logic     r_start, n_start;
    logic     r_out_valid;
    t_cand    r_out_data;
    logic     r_out_prime;

    t_div_req w_req;
    t_div_rsp w_rsp;
    t_value   w_cand;
    logic     w_accept;
    logic     w_out_free;

    assign w_cand     = to_value(i_s_tdata);
    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    assign w_req.start    = r_start;
    assign w_req.dividend = r_n;
    assign w_req.divisor  = r_d;

    tdpt_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    // Sequencer: settle trivial cases at once, otherwise step the divisor by two.
    always_comb begin
        n_state = r_state;
        n_d     = r_d;
        n_prime = r_prime;
        n_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_d = VALUE_WIDTH'(3);
                    if (w_cand < VALUE_WIDTH'(2)) begin
                        n_prime = 1'b0;
                        n_state = S_DONE;
                    end else if (w_cand == VALUE_WIDTH'(2)) begin
                        n_prime = 1'b1;
                        n_state = S_DONE;
                    end else if (!w_cand[0]) begin
                        n_prime = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_start = 1'b1;
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (w_rsp.done) begin
                    if (r_d > w_rsp.quotient) begin
                        // divisor squared exceeds the candidate: no factor left
                        n_prime = 1'b1;
                        n_state = S_DONE;
                    end else if (w_rsp.rem_zero) begin
                        n_prime = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_d     = r_d + VALUE_WIDTH'(2);
                        n_start = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= n_start;
            // Load the output register from the done state; drop it once taken.
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        r_d     <= n_d;
        r_prime <= n_prime;
        if (w_accept) begin
            r_n <= w_cand;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out_data  <= to_cand(r_n);
            r_out_prime <= r_prime;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_prime;

    a_start_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> (r_state == S_RUN))
        else $error("division started outside the run state");
    a_done_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_RUN))
        else $error("division finished outside the run state");
    a_divisor_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_d[0] && r_d >= VALUE_WIDTH'(3)))
        else $error("trial divisor is not an odd value of three or more");
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> (o_m_tvalid && r_state == S_IDLE))
        else $error("finished test was not moved to the output");
    a_one_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_start || w_rsp.busy || w_rsp.done))
        else $error("run state with no division in progress");

endmodule

`default_nettype wire
